/* hw/rtl/u8u16_pkg.sv */
// Shared types, constants and helpers of the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    localparam logic [15:0] REPL_UNIT      = 16'hFFFD;
    localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
    localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
    localparam logic [20:0] MAX_CODE_POINT = 21'h10FFFF;
    localparam logic [20:0] SURR_FIRST     = 21'h00D800;
    localparam logic [20:0] SURR_LAST      = 21'h00DFFF;
    localparam logic [20:0] SUPP_BASE      = 21'h010000;

    // One decoded byte: a number of replacement words, then optionally one code point.
    typedef struct packed {
        logic [2:0]  repl_count;
        logic        has_cp;
        logic [20:0] cp;
        logic        eot;
    } cmd_t;

    // Smallest value that a sequence with the given number of continuation bytes may carry.
    function automatic logic [20:0] min_value(input logic [1:0] len);
        logic [20:0] v;
        case (len)
            2'd1:    v = 21'h000080;
            2'd2:    v = 21'h000800;
            2'd3:    v = 21'h010000;
            default: v = 21'h000000;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/u8u16_front.sv */
// Byte decoder: tracks the open UTF-8 sequence and turns each byte into a command.
module u8u16_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       in_byte,
    input  logic             end_of_text,
    output logic             cmd_push,
    output u8u16_pkg::cmd_t  cmd
);

    typedef enum logic [1:0] {
        LEAD_ASCII,
        LEAD_OPEN,
        LEAD_BAD
    } lead_t;

    logic [1:0]  pend_reg, pend_next;
    logic [1:0]  coll_reg, coll_next;
    logic [20:0] part_reg, part_next;

    lead_t       lead_cls;
    logic [1:0]  lead_len;
    logic [20:0] lead_bits;

    logic [20:0] shifted;
    logic [1:0]  coll_inc;
    logic        use_lead;
    logic [2:0]  repl;
    logic        has_cp;
    logic [20:0] cp;

    always_comb
    begin
        lead_cls  = LEAD_BAD;
        lead_len  = 2'd0;
        lead_bits = 21'd0;
        if (!in_byte[7])
        begin
            lead_cls = LEAD_ASCII;
        end
        else if (in_byte[7:5] == 3'b110)
        begin
            lead_cls  = LEAD_OPEN;
            lead_len  = 2'd1;
            lead_bits = {16'd0, in_byte[4:0]};
        end
        else if (in_byte[7:4] == 4'b1110)
        begin
            lead_cls  = LEAD_OPEN;
            lead_len  = 2'd2;
            lead_bits = {17'd0, in_byte[3:0]};
        end
        else if (in_byte[7:3] == 5'b11110)
        begin
            lead_cls  = LEAD_OPEN;
            lead_len  = 2'd3;
            lead_bits = {18'd0, in_byte[2:0]};
        end
    end

    always_comb
    begin
        pend_next = pend_reg;
        coll_next = coll_reg;
        part_next = part_reg;
        repl      = 3'd0;
        has_cp    = 1'b0;
        cp        = 21'd0;
        use_lead  = 1'b0;
        shifted   = {part_reg[14:0], in_byte[5:0]};
        coll_inc  = coll_reg + 2'd1;

        if (pend_reg != 2'd0)
        begin
            if (in_byte[7:6] == 2'b10)
            begin
                if (coll_inc == pend_reg)
                begin
                    pend_next = 2'd0;
                    coll_next = 2'd0;
                    part_next = 21'd0;
                    if (shifted < u8u16_pkg::min_value(pend_reg))
                    begin
                        // Overlong form: one replacement per byte of the sequence.
                        repl = {1'b0, pend_reg} + 3'd1;
                    end
                    else if (shifted > u8u16_pkg::MAX_CODE_POINT ||
                             (shifted >= u8u16_pkg::SURR_FIRST &&
                              shifted <= u8u16_pkg::SURR_LAST))
                    begin
                        repl = 3'd1;
                    end
                    else
                    begin
                        has_cp = 1'b1;
                        cp     = shifted;
                    end
                end
                else
                begin
                    coll_next = coll_inc;
                    part_next = shifted;
                end
            end
            else
            begin
                // Interrupted sequence; the interrupting byte is retried as a lead.
                repl      = {1'b0, coll_reg} + 3'd1;
                pend_next = 2'd0;
                coll_next = 2'd0;
                part_next = 21'd0;
                use_lead  = 1'b1;
            end
        end
        else
        begin
            use_lead = 1'b1;
        end

        if (use_lead)
        begin
            case (lead_cls)
                LEAD_ASCII:
                begin
                    has_cp = 1'b1;
                    cp     = {13'd0, in_byte};
                end
                LEAD_OPEN:
                begin
                    pend_next = lead_len;
                    coll_next = 2'd0;
                    part_next = lead_bits;
                end
                default:
                begin
                    repl = repl + 3'd1;
                end
            endcase
        end

        if (end_of_text && pend_next != 2'd0)
        begin
            repl = repl + {1'b0, coll_next} + 3'd1;
        end
        if (end_of_text)
        begin
            pend_next = 2'd0;
            coll_next = 2'd0;
            part_next = 21'd0;
        end
    end

    assign cmd_push       = accept && (repl != 3'd0 || has_cp);
    assign cmd.repl_count = repl;
    assign cmd.has_cp     = has_cp;
    assign cmd.cp         = cp;
    assign cmd.eot        = end_of_text;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
            coll_reg <= 2'd0;
            part_reg <= 21'd0;
        end
        else if (accept)
        begin
            pend_reg <= pend_next;
            coll_reg <= coll_next;
            part_reg <= part_next;
        end
    end

endmodule

/* hw/rtl/u8u16_queue.sv */
// Short command queue between the byte decoder and the word expander.
module u8u16_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  u8u16_pkg::cmd_t  wr_data,
    input  logic             pop,
    output u8u16_pkg::cmd_t  rd_data,
    output logic             full,
    output logic             nonempty
);

    u8u16_pkg::cmd_t                  mem_reg [u8u16_pkg::QUEUE_DEPTH];
    logic [u8u16_pkg::QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [u8u16_pkg::QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [u8u16_pkg::QUEUE_CW-1:0]   count_reg, count_next;

    assign full     = (count_reg == u8u16_pkg::QUEUE_CW'(u8u16_pkg::QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + u8u16_pkg::QUEUE_CW'(push) - u8u16_pkg::QUEUE_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* hw/rtl/u8u16_back.sv */
// Word expander: turns queued commands into UTF-16 words, one per cycle when popped.
module u8u16_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_nonempty,
    input  u8u16_pkg::cmd_t  q_data,
    output logic             q_pop,
    input  logic             pop,
    output logic             empty,
    output logic [15:0]      code_unit,
    output logic             replaced,
    output logic             last_of_run,
    output logic             text_done
);

    logic [1:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    logic [15:0] unit_reg;
    logic        rep_reg;
    logic        last_reg;
    logic        done_reg;

    logic        is_supp;
    logic [2:0]  cp_units;
    logic [2:0]  total;
    logic [2:0]  idx_ext;
    logic [20:0] cp_off;
    logic [15:0] unit;
    logic        rep;
    logic        last;
    logic        take;

    always_comb
    begin
        is_supp  = (q_data.cp[20:16] != 5'd0);
        cp_units = q_data.has_cp ? (is_supp ? 3'd2 : 3'd1) : 3'd0;
        total    = q_data.repl_count + cp_units;
        idx_ext  = {1'b0, idx_reg};
        cp_off   = q_data.cp - u8u16_pkg::SUPP_BASE;
        // Replacement words come first, then the code point or its surrogate pair.
        if (idx_ext < q_data.repl_count)
        begin
            unit = u8u16_pkg::REPL_UNIT;
            rep  = 1'b1;
        end
        else if (idx_ext == q_data.repl_count)
        begin
            unit = is_supp ? (u8u16_pkg::HIGH_SURR_BASE | {6'd0, cp_off[19:10]})
                           : q_data.cp[15:0];
            rep  = 1'b0;
        end
        else
        begin
            unit = u8u16_pkg::LOW_SURR_BASE | {6'd0, q_data.cp[9:0]};
            rep  = 1'b0;
        end
        last = ((idx_ext + 3'd1) == total);
        take = q_nonempty && (!valid_reg || pop);

        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (take)
        begin
            idx_next   = last ? 2'd0 : idx_reg + 2'd1;
            valid_next = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    assign q_pop       = take && last;
    assign empty       = !valid_reg;
    assign code_unit   = unit_reg;
    assign replaced    = rep_reg;
    assign last_of_run = last_reg;
    assign text_done   = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            unit_reg <= unit;
            rep_reg  <= rep;
            last_reg <= last;
            done_reg <= last && q_data.eot;
        end
    end

endmodule

/* hw/rtl/utf8_to_utf16_transcoder.sv */
// Top level of the UTF-8 to UTF-16 transcoder.
// The block takes one UTF-8 byte per cycle while full is low and delivers UTF-16
// words at one word per cycle while pop is high, from a registered output stage, so
// well-formed text below U+10000 streams through at full rate. A byte gives
// zero to four words (a surrogate pair or a burst of U+FFFD for malformed input); the
// decoder hands its result to a four-entry command queue, and full rises only when
// that queue is full, which happens when bursts arrive faster than the word expander
// drains them at one word per cycle or when pop is held low. last_of_run marks the
// final word of a byte and text_done the final word of a string; a byte that only
// opens or extends a sequence gives no word.
module utf8_to_utf16_transcoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    input  logic        end_of_text,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] code_unit,
    output logic        replaced,
    output logic        last_of_run,
    output logic        text_done
);

    logic            accept;
    logic            cmd_push;
    u8u16_pkg::cmd_t cmd;
    u8u16_pkg::cmd_t q_data;
    logic            q_pop;
    logic            q_nonempty;

    assign accept = push && !full;

    u8u16_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .cmd_push    (cmd_push),
        .cmd         (cmd)
    );

    u8u16_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .wr_data  (cmd),
        .pop      (q_pop),
        .rd_data  (q_data),
        .full     (full),
        .nonempty (q_nonempty)
    );

    u8u16_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_nonempty  (q_nonempty),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .code_unit   (code_unit),
        .replaced    (replaced),
        .last_of_run (last_of_run),
        .text_done   (text_done)
    );

    // The end of a string always closes the run of its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && text_done) |-> last_of_run)
    else $error("text_done without last_of_run");

    // A replacement word always carries U+FFFD.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && replaced) |-> (code_unit == u8u16_pkg::REPL_UNIT))
    else $error("replaced word is not U+FFFD");

    // A high surrogate is never the last word of its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && code_unit[15:10] == 6'b110110) |-> !last_of_run)
    else $error("high surrogate closes a run");

    // The expander releases a queue entry only when one is there.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_nonempty)
    else $error("command queue underflow");

endmodule
